>>> src/fet_pkg.sv
// Package for the Fourier excitation trajectory generator.
// Holds the command and status types, codes and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps

package fet_pkg;

    // Fixed widths of the interface and internal arithmetic.
    localparam int TICK_W  = 17;
    localparam int PPP_W   = 16;
    localparam int CFG_W   = 23;
    localparam int COEF_W  = 32;
    localparam int ACC_W   = 64;

    // Input function codes.
    localparam logic [1:0] FUNC_WRITE_COEF = 2'd0;
    localparam logic [1:0] FUNC_SET_ANGLE  = 2'd1;
    localparam logic [1:0] FUNC_START      = 2'd2;
    localparam logic [1:0] FUNC_TICK       = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_POINTS_PER_PERIOD = 3'd0;
    localparam logic [2:0] CFG_LAST_POINT        = 3'd1;
    localparam logic [2:0] CFG_FUNDAMENTAL_RATE  = 3'd2;
    localparam logic [2:0] CFG_INVERSE_RATE      = 3'd3;
    localparam logic [2:0] CFG_JOINT_ENABLE_MASK = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] PPP_RESET  = 16'd1000;
    localparam logic [15:0] LAST_RESET = 16'd1000;
    localparam logic [22:0] FR_RESET   = 23'd41176;
    localparam logic [22:0] IR_RESET   = 23'd104308;
    localparam logic [5:0]  MASK_RESET = 6'd63;

    // Radians to degrees in Q16 and the clamp applied before conversion.
    localparam logic signed [23:0] R2D_Q16   = 24'sd3754936;
    localparam logic signed [63:0] RAD_LIMIT = 64'sh0000_0040_0000_0000;
    localparam logic signed [63:0] DEG_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] DEG_MIN   = 64'shFFFF_FFFF_8000_0000;
    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam longint Q30_ONE     = 64'd1073741824;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_WR_COEF,
        OP_WR_ANGLE,
        OP_CLR_TICK,
        OP_PH_INIT,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_ROM_S,
        OP_ROM_C,
        OP_STORE_C,
        OP_RD_A,
        OP_RD_B,
        OP_LAT_B,
        OP_MUL,
        OP_COMB,
        OP_SCALE,
        OP_KMUL,
        OP_KDIV,
        OP_ACC,
        OP_RD_Q,
        OP_POS_SUM,
        OP_TD_MUL,
        OP_TD_SAT,
        OP_EMIT,
        OP_EMIT_DONE
    } dp_op_t;

    // Which quantity the degree conversion works on.
    typedef enum logic [1:0] {
        SEL_POS,
        SEL_VEL,
        SEL_ACC
    } td_sel_t;

    typedef struct packed {
        dp_op_t  op;
        td_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
        logic kdiv_last;
        logic k_last;
        logic j_last;
        logic tick_over;
        logic out_free;
    } dp_status_t;

    // Quarter-wave sine in Q1.30 for table entry u of a quarter of 2^qbits.
    // Evaluated at elaboration only, to fill the constant table.
    function automatic logic signed [31:0] sine_q30(input int unsigned u,
                                                    input int unsigned qbits);
        longint x;
        longint x2;
        longint t;
        longint s;
        x  = (longint'(u) * HALF_PI_Q30) >>> qbits;
        x2 = (x * x) >>> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((t * x2) >>> 30) / 110;
        t  = Q30_ONE - ((t * x2) >>> 30) / 72;
        t  = Q30_ONE - ((t * x2) >>> 30) / 42;
        t  = Q30_ONE - ((t * x2) >>> 30) / 20;
        t  = Q30_ONE - ((t * x2) >>> 30) / 6;
        s  = (x * t) >>> 30;
        return 32'(s);
    endfunction

endpackage

>>> src/fet_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fet_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 66
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/fet_ctrl.sv
// Controller of the trajectory generator: sequences phase, term and
// conversion steps. Depends on fet_pkg.
`timescale 1ns / 1ps

module fet_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          func,
    output fet_pkg::dp_cmd_t    cmd,
    input  fet_pkg::dp_status_t status
);
    import fet_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DONE,
        ST_DIV_LOAD,
        ST_DIV,
        ST_ROM_S,
        ST_ROM_C,
        ST_STORE_C,
        ST_RD_A,
        ST_RD_B,
        ST_LAT_B,
        ST_MUL,
        ST_COMB,
        ST_SCALE,
        ST_KMUL,
        ST_KDIV,
        ST_ACC,
        ST_RD_Q,
        ST_POS_SUM,
        ST_TD_PM,
        ST_TD_PS,
        ST_TD_VM,
        ST_TD_VS,
        ST_TD_AM,
        ST_TD_AS,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   running_reg;
    logic   running_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and the command for the current cycle.
    always_comb
    begin
        state_next   = state_reg;
        running_next = running_reg;
        cmd.op       = OP_NONE;
        cmd.sel      = SEL_POS;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_WRITE_COEF: cmd.op = OP_WR_COEF;
                        FUNC_SET_ANGLE:  cmd.op = OP_WR_ANGLE;
                        FUNC_START:
                        begin
                            cmd.op       = OP_CLR_TICK;
                            running_next = 1'b1;
                        end
                        default:
                        begin
                            if (running_reg)
                            begin
                                if (status.tick_over)
                                begin
                                    cmd.op       = OP_CLR_TICK;
                                    running_next = 1'b0;
                                    state_next   = ST_DONE;
                                end
                                else
                                begin
                                    cmd.op     = OP_PH_INIT;
                                    state_next = ST_DIV_LOAD;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_LOAD:
            begin
                cmd.op     = OP_DIV_LOAD;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = ST_ROM_S;
                end
            end
            ST_ROM_S:
            begin
                cmd.op     = OP_ROM_S;
                state_next = ST_ROM_C;
            end
            ST_ROM_C:
            begin
                cmd.op     = OP_ROM_C;
                state_next = ST_STORE_C;
            end
            ST_STORE_C:
            begin
                cmd.op     = OP_STORE_C;
                state_next = status.k_last ? ST_RD_A : ST_DIV_LOAD;
            end
            ST_RD_A:
            begin
                cmd.op     = OP_RD_A;
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                cmd.op     = OP_RD_B;
                state_next = ST_LAT_B;
            end
            ST_LAT_B:
            begin
                cmd.op     = OP_LAT_B;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = ST_COMB;
            end
            ST_COMB:
            begin
                cmd.op     = OP_COMB;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = ST_KMUL;
            end
            ST_KMUL:
            begin
                cmd.op     = OP_KMUL;
                state_next = ST_KDIV;
            end
            ST_KDIV:
            begin
                cmd.op = OP_KDIV;
                if (status.kdiv_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = status.k_last ? ST_RD_Q : ST_RD_A;
            end
            ST_RD_Q:
            begin
                cmd.op     = OP_RD_Q;
                state_next = ST_POS_SUM;
            end
            ST_POS_SUM:
            begin
                cmd.op     = OP_POS_SUM;
                state_next = ST_TD_PM;
            end
            ST_TD_PM:
            begin
                cmd.op     = OP_TD_MUL;
                cmd.sel    = SEL_POS;
                state_next = ST_TD_PS;
            end
            ST_TD_PS:
            begin
                cmd.op     = OP_TD_SAT;
                cmd.sel    = SEL_POS;
                state_next = ST_TD_VM;
            end
            ST_TD_VM:
            begin
                cmd.op     = OP_TD_MUL;
                cmd.sel    = SEL_VEL;
                state_next = ST_TD_VS;
            end
            ST_TD_VS:
            begin
                cmd.op     = OP_TD_SAT;
                cmd.sel    = SEL_VEL;
                state_next = ST_TD_AM;
            end
            ST_TD_AM:
            begin
                cmd.op     = OP_TD_MUL;
                cmd.sel    = SEL_ACC;
                state_next = ST_TD_AS;
            end
            ST_TD_AS:
            begin
                cmd.op     = OP_TD_SAT;
                cmd.sel    = SEL_ACC;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = status.j_last ? ST_IDLE : ST_RD_A;
                end
            end
        endcase
    end

    // State and run flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            running_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
        end
    end

endmodule

>>> src/fet_datapath.sv
// Datapath of the trajectory generator: configuration, coefficient store,
// phase divider, sine table, multiply-accumulate and output register.
// Depends on fet_pkg and fet_ram.
`timescale 1ns / 1ps

module fet_datapath #(
    parameter int JOINTS          = 6,
    parameter int HARMONICS       = 5,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fet_pkg::dp_cmd_t    cmd,
    output fet_pkg::dp_status_t status,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [22:0]         cfg_data,
    input  logic [6:0]          coef_index,
    input  logic signed [31:0]  coef_value,
    input  logic [2:0]          joint_sel,
    input  logic signed [31:0]  start_angle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          joint,
    output logic signed [31:0]  position_deg,
    output logic signed [31:0]  velocity_deg,
    output logic signed [31:0]  accel_deg,
    output logic                done_res,
    output logic                last
);
    import fet_pkg::*;

    localparam int SLOTS   = 2 * HARMONICS + 1;
    localparam int DEPTH   = JOINTS * SLOTS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int KIDX_W  = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
    localparam int JIDX_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int KW      = $clog2(HARMONICS + 1);
    localparam int QBITS   = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QBITS;
    localparam int DN_W    = TICK_W + KW + SINE_TABLE_BITS;
    localparam int DCNT_W  = $clog2(DN_W);
    localparam int KD_W    = 64;
    localparam int KD_STEP = 8;
    localparam int KD_CYC  = KD_W / KD_STEP;
    localparam int KDC_W   = $clog2(KD_CYC);

    // Configuration registers.
    logic [15:0] ppp_reg;
    logic [15:0] last_reg;
    logic [22:0] fr_reg;
    logic [22:0] ir_reg;
    logic [5:0]  mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppp_reg  <= PPP_RESET;
            last_reg <= LAST_RESET;
            fr_reg   <= FR_RESET;
            ir_reg   <= IR_RESET;
            mask_reg <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POINTS_PER_PERIOD: ppp_reg  <= cfg_data[15:0];
                CFG_LAST_POINT:        last_reg <= cfg_data[15:0];
                CFG_FUNDAMENTAL_RATE:  fr_reg   <= cfg_data;
                CFG_INVERSE_RATE:      ir_reg   <= cfg_data;
                CFG_JOINT_ENABLE_MASK: mask_reg <= cfg_data[5:0];
                default:               ;
            endcase
        end
    end

    // Control registers.
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_next;
    logic [KIDX_W-1:0] k_reg;
    logic [KIDX_W-1:0] k_next;
    logic [JIDX_W-1:0] j_reg;
    logic [JIDX_W-1:0] j_next;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [DCNT_W-1:0] div_cnt_next;
    logic [KDC_W-1:0]  kd_cnt_reg;
    logic [KDC_W-1:0]  kd_cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              k_last;
    logic              j_last;
    logic              out_load;

    assign k_last   = (k_reg == KIDX_W'(HARMONICS - 1));
    assign j_last   = (j_reg == JIDX_W'(JOINTS - 1));
    assign out_load = (cmd.op == OP_EMIT) || (cmd.op == OP_EMIT_DONE);

    // Coefficient store.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;
    logic [ADDR_W-1:0] row_base;

    assign ram_we   = (cmd.op == OP_WR_COEF) && ($unsigned(coef_index) < DEPTH);
    assign row_base = ADDR_W'(int'(j_reg) * SLOTS);

    always_comb
    begin
        ram_raddr = row_base;
        unique case (cmd.op)
            OP_RD_A: ram_raddr = ADDR_W'(int'(row_base) + int'(k_reg));
            OP_RD_B: ram_raddr = ADDR_W'(int'(row_base) + HARMONICS + int'(k_reg));
            OP_RD_Q: ram_raddr = ADDR_W'(int'(row_base) + 2 * HARMONICS);
            default: ram_raddr = row_base;
        endcase
    end

    fet_ram #(
        .WIDTH (COEF_W),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(coef_index)),
        .wdata (coef_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Start angles, one per joint.
    logic [31:0] angle_reg [JOINTS];

    always_ff @(posedge clk)
    begin
        if ((cmd.op == OP_WR_ANGLE) && ($unsigned(joint_sel) < JOINTS))
        begin
            angle_reg[JIDX_W'(joint_sel)] <= start_angle;
        end
    end

    // Phase divider: one restoring step a cycle. Shifting in k*p and then
    // table-width zeros leaves the table index in the low quotient bits.
    logic [DN_W-1:0]         div_num_reg;
    logic [15:0]             div_rem_reg;
    logic [KW-1:0]           kk;
    logic [TICK_W+KW-1:0]    kp;
    logic [15:0]             ppp_eff;
    logic [16:0]             rem_sh;
    logic                    div_ge;
    logic [16:0]             rem_sub;

    assign kk      = KW'(k_reg) + KW'(1);
    assign kp      = kk * tick_reg;
    assign ppp_eff = (ppp_reg < 16'd2) ? 16'd2 : ppp_reg;
    assign rem_sh  = {div_rem_reg, div_num_reg[DN_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, ppp_eff});
    assign rem_sub = rem_sh - {1'b0, ppp_eff};

    // Quarter-wave sine table.
    logic signed [31:0] sine_rom [QUARTER + 1];

    for (genvar gi = 0; gi <= QUARTER; gi++)
    begin : g_rom
        assign sine_rom[gi] = sine_q30(gi, QBITS);
    end

    logic [SINE_TABLE_BITS-1:0] tab_idx;
    logic [SINE_TABLE_BITS-1:0] rom_idx;
    logic [1:0]                 rom_quad;
    logic [QBITS:0]             rom_u;
    logic signed [31:0]         rom_q_reg;
    logic                       rom_neg_reg;
    logic signed [31:0]         rom_val;

    assign tab_idx  = div_num_reg[SINE_TABLE_BITS-1:0];
    assign rom_idx  = (cmd.op == OP_ROM_C) ?
                      tab_idx + SINE_TABLE_BITS'(QUARTER) : tab_idx;
    assign rom_quad = rom_idx[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
    assign rom_u    = rom_quad[0] ? (QBITS + 1)'(QUARTER) - {1'b0, rom_idx[QBITS-1:0]}
                                  : {1'b0, rom_idx[QBITS-1:0]};
    assign rom_val  = rom_neg_reg ? -rom_q_reg : rom_q_reg;

    logic signed [31:0] sin_reg [HARMONICS];
    logic signed [31:0] cos_reg [HARMONICS];

    // Term arithmetic.
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [63:0] p_as_reg;
    logic signed [63:0] p_bc_reg;
    logic signed [63:0] p_ac_reg;
    logic signed [63:0] p_bs_reg;
    logic signed [33:0] ps_reg;
    logic signed [33:0] pa_reg;
    logic signed [57:0] pt_reg;
    logic signed [57:0] at_reg;
    logic signed [63:0] at2_reg;
    logic signed [ACC_W-1:0] pos_acc_reg;
    logic signed [ACC_W-1:0] vel_acc_reg;
    logic signed [ACC_W-1:0] acc_acc_reg;
    logic signed [63:0] diff;
    logic signed [63:0] pt_ext;
    logic signed [23:0] ir_s;
    logic signed [23:0] fr_s;

    assign diff   = p_as_reg - p_bc_reg;
    assign pt_ext = 64'(pt_reg);
    assign ir_s   = $signed({1'b0, ir_reg});
    assign fr_s   = $signed({1'b0, fr_reg});

    // Division of the position term by the harmonic number, eight
    // restoring steps a cycle on the magnitude.
    logic [KD_W-1:0] kd_num_reg;
    logic [KW-1:0]   kd_rem_reg;
    logic            kd_neg_reg;
    logic [KD_W-1:0] kd_num_step;
    logic [KW-1:0]   kd_rem_step;
    logic signed [63:0] kd_quot;

    always_comb
    begin
        logic [KW:0] r_sh;
        logic        ge;
        kd_num_step = kd_num_reg;
        kd_rem_step = kd_rem_reg;
        for (int i = 0; i < KD_STEP; i++)
        begin
            r_sh = {kd_rem_step, kd_num_step[KD_W-1]};
            ge   = (r_sh >= {1'b0, kk});
            kd_rem_step = ge ? KW'(r_sh - {1'b0, kk}) : r_sh[KW-1:0];
            kd_num_step = {kd_num_step[KD_W-2:0], ge};
        end
    end

    assign kd_quot = kd_neg_reg ? -$signed(kd_num_reg) : $signed(kd_num_reg);

    // Degree conversion: clamp and scale, then shift and saturate.
    logic signed [63:0] pos_rad_reg;
    logic signed [62:0] td_prod_reg;
    logic signed [63:0] td_src;
    logic signed [39:0] td_clamp;
    logic signed [62:0] td_sh;
    logic signed [31:0] td_sat;
    logic signed [31:0] res_pos_reg;
    logic signed [31:0] res_vel_reg;
    logic signed [31:0] res_acc_reg;

    always_comb
    begin
        unique case (cmd.sel)
            SEL_POS: td_src = pos_rad_reg;
            SEL_VEL: td_src = vel_acc_reg;
            SEL_ACC: td_src = acc_acc_reg >>> 16;
            default: td_src = '0;
        endcase
        if (td_src > RAD_LIMIT)
        begin
            td_clamp = 40'(RAD_LIMIT);
        end
        else if (td_src < -RAD_LIMIT)
        begin
            td_clamp = 40'(-RAD_LIMIT);
        end
        else
        begin
            td_clamp = 40'(td_src);
        end
    end

    always_comb
    begin
        td_sh = td_prod_reg >>> 28;
        if (64'(td_sh) > DEG_MAX)
        begin
            td_sat = 32'(DEG_MAX);
        end
        else if (64'(td_sh) < DEG_MIN)
        begin
            td_sat = 32'(DEG_MIN);
        end
        else
        begin
            td_sat = 32'(td_sh);
        end
    end

    // Output register.
    logic [7:0]  mask_ext;
    logic [31:0] pos_out;

    assign mask_ext = 8'(mask_reg);
    assign pos_out  = mask_ext[3'(j_reg)] ? res_pos_reg : angle_reg[j_reg];

    logic [2:0]         joint_reg;
    logic signed [31:0] position_reg;
    logic signed [31:0] velocity_reg;
    logic signed [31:0] accel_reg;
    logic               done_reg;
    logic               last_reg_o;

    // Next values of the control registers.
    always_comb
    begin
        tick_next      = tick_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        div_cnt_next   = div_cnt_reg;
        kd_cnt_next    = kd_cnt_reg;
        out_valid_next = out_load || (out_valid_reg && !out_ready);
        unique case (cmd.op)
            OP_CLR_TICK: tick_next = '0;
            OP_PH_INIT:  k_next = '0;
            OP_DIV_LOAD: div_cnt_next = '0;
            OP_DIV_STEP: div_cnt_next = div_cnt_reg + DCNT_W'(1);
            OP_STORE_C:
            begin
                k_next = k_last ? '0 : k_reg + KIDX_W'(1);
                if (k_last)
                begin
                    j_next = '0;
                end
            end
            OP_KMUL:     kd_cnt_next = '0;
            OP_KDIV:     kd_cnt_next = kd_cnt_reg + KDC_W'(1);
            OP_ACC:      k_next = k_last ? '0 : k_reg + KIDX_W'(1);
            OP_EMIT:
            begin
                j_next = j_last ? '0 : j_reg + JIDX_W'(1);
                if (j_last)
                begin
                    tick_next = tick_reg + TICK_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            div_cnt_reg   <= '0;
            kd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tick_reg      <= tick_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            div_cnt_reg   <= div_cnt_next;
            kd_cnt_reg    <= kd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, one operation a cycle.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_DIV_LOAD:
            begin
                div_num_reg <= {kp, SINE_TABLE_BITS'(0)};
                div_rem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                div_num_reg <= {div_num_reg[DN_W-2:0], div_ge};
                div_rem_reg <= div_ge ? rem_sub[15:0] : rem_sh[15:0];
            end
            OP_ROM_S:
            begin
                rom_q_reg   <= sine_rom[rom_u];
                rom_neg_reg <= rom_quad[1];
            end
            OP_ROM_C:
            begin
                sin_reg[k_reg] <= rom_val;
                rom_q_reg      <= sine_rom[rom_u];
                rom_neg_reg    <= rom_quad[1];
            end
            OP_STORE_C:
            begin
                cos_reg[k_reg] <= rom_val;
                if (k_last)
                begin
                    pos_acc_reg <= '0;
                    vel_acc_reg <= '0;
                    acc_acc_reg <= '0;
                end
            end
            OP_RD_B:  a_reg <= $signed(ram_rdata);
            OP_LAT_B: b_reg <= $signed(ram_rdata);
            OP_MUL:
            begin
                p_as_reg <= a_reg * sin_reg[k_reg];
                p_bc_reg <= b_reg * cos_reg[k_reg];
                p_ac_reg <= a_reg * cos_reg[k_reg];
                p_bs_reg <= b_reg * sin_reg[k_reg];
            end
            OP_COMB:
            begin
                ps_reg      <= 34'(diff >>> 30);
                pa_reg      <= 34'((-diff) >>> 30);
                vel_acc_reg <= vel_acc_reg + ((p_ac_reg + p_bs_reg) >>> 30);
            end
            OP_SCALE:
            begin
                pt_reg <= ps_reg * ir_s;
                at_reg <= pa_reg * fr_s;
            end
            OP_KMUL:
            begin
                at2_reg    <= at_reg * $signed({1'b0, kk});
                kd_num_reg <= pt_reg[57] ? KD_W'(-pt_ext) : KD_W'(pt_ext);
                kd_rem_reg <= '0;
                kd_neg_reg <= pt_reg[57];
            end
            OP_KDIV:
            begin
                kd_num_reg <= kd_num_step;
                kd_rem_reg <= kd_rem_step;
            end
            OP_ACC:
            begin
                pos_acc_reg <= pos_acc_reg + kd_quot;
                acc_acc_reg <= acc_acc_reg + at2_reg;
            end
            OP_POS_SUM:
            begin
                pos_rad_reg <= (pos_acc_reg >>> 16) + 64'($signed(ram_rdata));
            end
            OP_TD_MUL: td_prod_reg <= 63'(td_clamp * R2D_Q16);
            OP_TD_SAT:
            begin
                unique case (cmd.sel)
                    SEL_POS: res_pos_reg <= td_sat;
                    SEL_VEL: res_vel_reg <= td_sat;
                    SEL_ACC: res_acc_reg <= td_sat;
                    default: ;
                endcase
            end
            OP_EMIT:
            begin
                joint_reg    <= 3'(j_reg);
                position_reg <= pos_out;
                velocity_reg <= res_vel_reg;
                accel_reg    <= res_acc_reg;
                done_reg     <= 1'b0;
                last_reg_o   <= j_last;
                pos_acc_reg  <= '0;
                vel_acc_reg  <= '0;
                acc_acc_reg  <= '0;
            end
            OP_EMIT_DONE:
            begin
                joint_reg    <= '0;
                position_reg <= '0;
                velocity_reg <= '0;
                accel_reg    <= '0;
                done_reg     <= 1'b1;
                last_reg_o   <= 1'b1;
            end
            default: ;
        endcase
    end

    // Status towards the controller and output ports.
    assign status.div_last  = (div_cnt_reg == DCNT_W'(DN_W - 1));
    assign status.kdiv_last = (kd_cnt_reg == KDC_W'(KD_CYC - 1));
    assign status.k_last    = k_last;
    assign status.j_last    = j_last;
    assign status.tick_over = (tick_reg > {1'b0, last_reg});
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign joint        = joint_reg;
    assign position_deg = position_reg;
    assign velocity_deg = velocity_reg;
    assign accel_deg    = accel_reg;
    assign done_res     = done_reg;
    assign last         = last_reg_o;

endmodule

>>> src/fourier_excitation_trajectory.sv
// Top level of the Fourier excitation trajectory generator.
// Depends on fet_pkg, fet_ctrl and fet_datapath.
`timescale 1ns / 1ps

// Each tick item produces one transfer per joint carrying target position,
// velocity and acceleration in Q16.16 degrees; once the tick index has passed
// last_point the next tick produces a single done result and stops the
// generator. Coefficient writes, start angle writes and start are carried out
// as they are accepted, and the controller stays idle. A running tick runs the
// bit-serial phase divider, one bit a cycle for each harmonic; then for each
// joint it uses the single coefficient RAM port (two reads per harmonic), the
// shared multiply stages and a division of each position term by its harmonic
// number, plus any wait on the output side. A new item is taken only once the
// previous tick has handed its last result to the output register.

module fourier_excitation_trajectory #(
    parameter int JOINTS          = 6,
    parameter int HARMONICS       = 5,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [22:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [6:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic [2:0]         joint_sel,
    input  logic signed [31:0] start_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         joint,
    output logic signed [31:0] position_deg,
    output logic signed [31:0] velocity_deg,
    output logic signed [31:0] accel_deg,
    output logic               done_res,
    output logic               last
);
    import fet_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    fet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .cmd      (cmd),
        .status   (status)
    );

    // Arithmetic, storage and output register.
    fet_datapath #(
        .JOINTS          (JOINTS),
        .HARMONICS       (HARMONICS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .joint_sel    (joint_sel),
        .start_angle  (start_angle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .joint        (joint),
        .position_deg (position_deg),
        .velocity_deg (velocity_deg),
        .accel_deg    (accel_deg),
        .done_res     (done_res),
        .last         (last)
    );

endmodule

>>> src/fet_checker.sv
// Port-level checks for the trajectory generator, attached by bind.
// Depends on fourier_excitation_trajectory.
`timescale 1ns / 1ps

module fet_checker #(
    parameter int JOINTS = 6
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  joint,
    input logic [31:0] position_deg,
    input logic [31:0] velocity_deg,
    input logic [31:0] accel_deg,
    input logic        done_res,
    input logic        last
);

    // A stalled result holds its joint, position, last and done fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(joint)
            && $stable(position_deg) && $stable(last) && $stable(done_res))
    else $error("result changed while stalled");

    // The done result is the only one of its tick and carries zeros.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> last && joint == 3'd0 && position_deg == 32'd0
            && velocity_deg == 32'd0 && accel_deg == 32'd0)
    else $error("malformed done result");

    // The closing result of a tick is the last joint.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res && last |-> joint == 3'(JOINTS - 1))
    else $error("tick closed on the wrong joint");

    // Earlier results of a tick name joints below the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !done_res && joint < 3'(JOINTS - 1))
    else $error("joint out of range");

endmodule

bind fourier_excitation_trajectory fet_checker #(.JOINTS(JOINTS)) u_fet_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .joint        (joint),
    .position_deg (position_deg),
    .velocity_deg (velocity_deg),
    .accel_deg    (accel_deg),
    .done_res     (done_res),
    .last         (last)
);
